// ===== sv/integer_to_ascii_formatter_defines.svh =====
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_defines.svh
// Assertion macros for the integer to ASCII formatter.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define I2A_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// Next-cycle implication, disabled during reset
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`else

`define I2A_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define I2A_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/i2a_pkg.sv =====
// ---------------------------------------------------------------------------
// i2a_pkg
// Shared types, codes and character helpers for the formatter.
// ---------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int VALUE_BITS_DEF = 32;

    // conversion kinds
    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_HEXL = 3'd3;
    localparam logic [2:0] KIND_HEXU = 3'd4;

    // sign modes
    localparam logic [1:0] SIGN_MINUS_ONLY = 2'd0;
    localparam logic [1:0] SIGN_PLUS       = 2'd1;
    localparam logic [1:0] SIGN_SPACE      = 2'd2;

    // characters
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_LOWA  = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CASE_GAP = 7'd32;

    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;

    typedef logic [4:0] base_t;
    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } cell_ctrl_t;

    // map one digit value to its ASCII code
    function automatic logic [6:0] digit_to_ascii(input digit_t d, input logic upper);
        logic [6:0] c;
        begin
            if (d > 4'd9) begin
                c = ({3'b000, d} - 7'd10) + CH_LOWA;
                if (upper) begin
                    c = c - CASE_GAP;
                end
            end else begin
                c = {3'b000, d} + CH_ZERO;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// ===== sv/integer_to_ascii_formatter.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter
// Converts one binary word into ASCII text, most significant digit first.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: value, req_type and
// sign_mode. Output channel (out_valid/out_ready) gives the text one
// character at a time, with last_char set on the final character.
// A row of digit cells converts the magnitude one bit per cycle, most
// significant bit first: each cell doubles its digit, adds the carry from
// the cell below and passes the overflow upward. The same row then shifts
// towards the top cell, which feeds the output register; leading zero
// digits are dropped.
// Each word is accepted, converted over VALUE_BITS bits (32 by default),
// then given an optional sign, then NUM_CELLS digits (11 by default) are
// emitted or dropped. One word is in work at a time; in_ready is high only
// while idle. A stalled receiver holds the output register and the
// emission of sign and digits, though leading zeros are still dropped;
// the last character may still wait in the output register while the
// next word is accepted. Reset returns to idle with the output register
// empty.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_formatter_defines.svh"

module integer_to_ascii_formatter
    import i2a_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    input  logic [2:0]  req_type,
    input  logic [1:0]  sign_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  ascii_char,
    output logic        last_char
);

    // octal needs the most digits of any radix
    localparam int NUM_CELLS = (VALUE_BITS + 2) / 3;
    localparam int CNT_W     = $clog2(VALUE_BITS + 1);
    localparam int EMIT_W    = $clog2(NUM_CELLS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } state_t;

    state_t                  state_reg,     state_next;
    logic [VALUE_BITS-1:0]   mag_reg,       mag_next;
    logic [CNT_W-1:0]        conv_cnt_reg,  conv_cnt_next;
    logic [EMIT_W-1:0]       emit_cnt_reg,  emit_cnt_next;
    base_t                   base_reg,      base_next;
    logic                    upper_reg,     upper_next;
    logic                    has_sign_reg,  has_sign_next;
    logic [6:0]              sign_reg,      sign_next;
    logic                    seen_reg,      seen_next;
    logic                    out_valid_reg, out_valid_next;
    logic [6:0]              ascii_reg,     ascii_next;
    logic                    last_reg,      last_next;

    logic [VALUE_BITS-1:0]   val_in;
    logic [VALUE_BITS-1:0]   val_mag;
    logic                    val_neg;
    logic                    out_free;
    cell_ctrl_t              cell_ctrl;
    logic [NUM_CELLS:0]      carry_w;
    digit_t                  digit_w [NUM_CELLS];
    digit_t                  top_digit;

    // take the low VALUE_BITS bits of the word, zero-extend if wider
    generate
        if (VALUE_BITS <= 32)
        begin : g_in_narrow
            assign val_in = value[VALUE_BITS-1:0];
        end
        else
        begin : g_in_wide
            assign val_in = {{(VALUE_BITS - 32){1'b0}}, value};
        end
    endgenerate

    // magnitude of a negative signed word; the most negative maps onto itself
    assign val_neg = (req_type == KIND_SDEC) && val_in[VALUE_BITS-1];
    assign val_mag = val_neg ? (~val_in + VALUE_BITS'(1)) : val_in;

    // bit stream enters the least significant cell
    assign carry_w[0] = mag_reg[VALUE_BITS-1];

    generate
        for (genvar i = 0; i < NUM_CELLS; i++)
        begin : g_cell
            digit_t nb_digit;
            if (i == 0)
            begin : g_first
                assign nb_digit = '0;
            end
            else
            begin : g_rest
                assign nb_digit = digit_w[i-1];
            end

            i2a_cell u_cell (
                .clk       (clk),
                .ctrl      (cell_ctrl),
                .base      (base_reg),
                .carry_in  (carry_w[i]),
                .digit_in  (nb_digit),
                .carry_out (carry_w[i+1]),
                .digit     (digit_w[i])
            );
        end
    endgenerate

    assign top_digit = digit_w[NUM_CELLS-1];
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        conv_cnt_next  = conv_cnt_reg;
        emit_cnt_next  = emit_cnt_reg;
        base_next      = base_reg;
        upper_next     = upper_reg;
        has_sign_next  = has_sign_reg;
        sign_next      = sign_reg;
        seen_next      = seen_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ascii_next     = ascii_reg;
        last_next      = last_reg;
        cell_ctrl      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // load the word and clear the digit row
                    cell_ctrl.clear = 1'b1;
                    mag_next        = val_mag;
                    conv_cnt_next   = CNT_W'(VALUE_BITS);
                    upper_next      = (req_type == KIND_HEXU);
                    unique case (req_type)
                        KIND_OCT:  base_next = BASE_OCT;
                        KIND_HEXL: base_next = BASE_HEX;
                        KIND_HEXU: base_next = BASE_HEX;
                        default:   base_next = BASE_DEC;
                    endcase
                    has_sign_next = 1'b0;
                    sign_next     = CH_MINUS;
                    if (req_type == KIND_SDEC)
                    begin
                        if (val_neg)
                        begin
                            has_sign_next = 1'b1;
                        end
                        else if (sign_mode == SIGN_PLUS)
                        begin
                            has_sign_next = 1'b1;
                            sign_next     = CH_PLUS;
                        end
                        else if (sign_mode == SIGN_SPACE)
                        begin
                            has_sign_next = 1'b1;
                            sign_next     = CH_SPACE;
                        end
                    end
                    state_next = S_CONV;
                end
            end

            S_CONV:
            begin
                // advance one bit through the cell row
                cell_ctrl.conv = 1'b1;
                mag_next       = mag_reg << 1;
                conv_cnt_next  = conv_cnt_reg - CNT_W'(1);
                if (conv_cnt_reg == CNT_W'(1))
                begin
                    emit_cnt_next = EMIT_W'(NUM_CELLS);
                    seen_next     = 1'b0;
                    state_next    = has_sign_reg ? S_SIGN : S_EMIT;
                end
            end

            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ascii_next     = sign_reg;
                    last_next      = 1'b0;
                    state_next     = S_EMIT;
                end
            end

            S_EMIT:
            begin
                if (!seen_reg && (top_digit == '0) && (emit_cnt_reg != EMIT_W'(1)))
                begin
                    // drop a leading zero
                    cell_ctrl.shift = 1'b1;
                    emit_cnt_next   = emit_cnt_reg - EMIT_W'(1);
                end
                else if (out_free)
                begin
                    cell_ctrl.shift = 1'b1;
                    emit_cnt_next   = emit_cnt_reg - EMIT_W'(1);
                    seen_next       = 1'b1;
                    out_valid_next  = 1'b1;
                    ascii_next      = digit_to_ascii(top_digit, upper_reg);
                    last_next       = (emit_cnt_reg == EMIT_W'(1));
                    if (emit_cnt_reg == EMIT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mag_reg       <= '0;
            conv_cnt_reg  <= '0;
            emit_cnt_reg  <= '0;
            base_reg      <= BASE_DEC;
            upper_reg     <= 1'b0;
            has_sign_reg  <= 1'b0;
            sign_reg      <= CH_MINUS;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ascii_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            conv_cnt_reg  <= conv_cnt_next;
            emit_cnt_reg  <= emit_cnt_next;
            base_reg      <= base_next;
            upper_reg     <= upper_next;
            has_sign_reg  <= has_sign_next;
            sign_reg      <= sign_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            ascii_reg     <= ascii_next;
            last_reg      <= last_next;
        end
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign ascii_char = ascii_reg;
    assign last_char  = last_reg;

    // an accepted word always starts a conversion pass
    `I2A_ASSERT_NEXT(a_accept_conv, clk, rst_n, in_valid && in_ready, state_reg == S_CONV)
    // the bit counter never runs out while converting
    `I2A_ASSERT_IMPL(a_conv_cnt, clk, rst_n, state_reg == S_CONV, conv_cnt_reg != '0)
    // the digit counter never runs out while emitting
    `I2A_ASSERT_IMPL(a_emit_cnt, clk, rst_n, state_reg == S_EMIT, emit_cnt_reg != '0)
    // the top cell always holds a legal digit of the current radix
    `I2A_ASSERT_IMPL(a_top_digit, clk, rst_n, state_reg == S_EMIT, {1'b0, top_digit} < base_reg)

endmodule

`default_nettype wire

// ===== sv/i2a_cell.sv =====
// ---------------------------------------------------------------------------
// i2a_cell
// One digit cell: doubles its digit plus carry in, takes its neighbour's, or clears.
// ---------------------------------------------------------------------------
`default_nettype none

module i2a_cell
    import i2a_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  base_t      base,
    input  logic       carry_in,
    input  digit_t     digit_in,
    output logic       carry_out,
    output digit_t     digit
);

    digit_t     digit_reg;
    digit_t     digit_next;
    logic [4:0] dbl;
    logic [4:0] dbl_sub;

    assign dbl       = {digit_reg, carry_in};
    assign dbl_sub   = dbl - base;
    // every radix is even, so the carry in never tips the compare; keep the
    // carry off the row-long ripple path
    assign carry_out = ({digit_reg, 1'b0} >= base);
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        priority if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.conv)
        begin
            // fold the overflow into the next cell
            digit_next = carry_out ? dbl_sub[3:0] : dbl[3:0];
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

`default_nettype wire
